### src/pdec_pkg.sv
// ----------------------------------------------------------------------------
// pdec_pkg
// Shared types, character codes and helper functions of the percent decoder.
// ----------------------------------------------------------------------------
package pdec_pkg;

   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [3:0] LETTER_OFFSET = 4'd9;
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   typedef enum logic [1:0] {
      PHASE_IDLE    = 2'd0,
      PHASE_PERCENT = 2'd1,
      PHASE_DIGIT   = 2'd2
   } escape_phase_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
   } rsp_payload_type;

   typedef struct packed {
      logic [2:0][7:0] data;
      logic [1:0]      count;
      logic            last;
   } cmd_type;

   function automatic logic hex_ok(input logic [7:0] c);
      hex_ok = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
               (c >= 8'h41 && c <= 8'h46);
   endfunction

   function automatic logic [3:0] hex_nibble(input logic [7:0] c);
      if (c <= 8'h39) begin
         hex_nibble = c[3:0];
      end else begin
         hex_nibble = c[3:0] + LETTER_OFFSET;
      end
   endfunction

endpackage

### src/pdec_front.sv
// ----------------------------------------------------------------------------
// pdec_front
// Tracks the escape phase and turns each input byte into a command of zero
// to three output bytes.
// ----------------------------------------------------------------------------
module pdec_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  pdec_pkg::req_payload_type req,
   output pdec_pkg::cmd_type         cmd,
   output logic                      push
);

   pdec_pkg::escape_phase_type phase_ff, phase_in;
   logic [7:0] held_ff, held_in;
   logic [1:0] n;
   logic       do_idle;
   logic [7:0] b;

   assign b = req.in_byte;

   always_comb begin
      cmd      = '0;
      cmd.last = req.in_last;
      n        = 2'd0;
      do_idle  = 1'b0;
      phase_in = phase_ff;
      held_in  = held_ff;
      case (phase_ff)
         pdec_pkg::PHASE_PERCENT: begin
            if (pdec_pkg::hex_ok(b)) begin
               if (req.in_last) begin
                  cmd.data[0] = pdec_pkg::CH_PERCENT;
                  cmd.data[1] = b;
                  n = 2'd2;
                  phase_in = pdec_pkg::PHASE_IDLE;
               end else begin
                  held_in  = b;
                  phase_in = pdec_pkg::PHASE_DIGIT;
               end
            end else begin
               cmd.data[0] = pdec_pkg::CH_PERCENT;
               n = 2'd1;
               do_idle = 1'b1;
            end
         end
         pdec_pkg::PHASE_DIGIT: begin
            if (pdec_pkg::hex_ok(b)) begin
               cmd.data[0] = {pdec_pkg::hex_nibble(held_ff), pdec_pkg::hex_nibble(b)};
               n = 2'd1;
               phase_in = pdec_pkg::PHASE_IDLE;
            end else begin
               cmd.data[0] = pdec_pkg::CH_PERCENT;
               cmd.data[1] = held_ff;
               n = 2'd2;
               do_idle = 1'b1;
            end
         end
         default: begin
            do_idle = 1'b1;
         end
      endcase
      if (do_idle) begin
         phase_in = pdec_pkg::PHASE_IDLE;
         if (b == pdec_pkg::CH_PERCENT) begin
            if (req.in_last) begin
               cmd.data[n] = pdec_pkg::CH_PERCENT;
               n = n + 2'd1;
            end else begin
               phase_in = pdec_pkg::PHASE_PERCENT;
            end
         end else if (b == pdec_pkg::CH_PLUS) begin
            cmd.data[n] = pdec_pkg::CH_SPACE;
            n = n + 2'd1;
         end else begin
            cmd.data[n] = b;
            n = n + 2'd1;
         end
      end
      cmd.count = n;
   end

   assign push = accept && (n != 2'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= pdec_pkg::PHASE_IDLE;
         held_ff  <= 8'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
      end
   end

endmodule

### src/pdec_queue.sv
// ----------------------------------------------------------------------------
// pdec_queue
// Four-entry command queue between the classifier and the output stage.
// ----------------------------------------------------------------------------
module pdec_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  pdec_pkg::cmd_type  push_cmd,
   input  logic               pop,
   output pdec_pkg::cmd_type  head_cmd,
   output logic               empty,
   output logic               full
);

   pdec_pkg::cmd_type entry_ff [pdec_pkg::QUEUE_DEPTH];
   logic [pdec_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [pdec_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [pdec_pkg::QUEUE_PTR_W:0]   count_ff, count_in;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == (pdec_pkg::QUEUE_PTR_W+1)'(pdec_pkg::QUEUE_DEPTH));
   assign head_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (pdec_pkg::QUEUE_PTR_W+1)'(push)
                  - (pdec_pkg::QUEUE_PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### src/pdec_back.sv
// ----------------------------------------------------------------------------
// pdec_back
// Walks the head command's bytes into the output register, one per cycle unless rsp_stall holds it.
// ----------------------------------------------------------------------------
module pdec_back (
   input  logic                      clock,
   input  logic                      reset,
   input  pdec_pkg::cmd_type         head_cmd,
   input  logic                      head_valid,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output pdec_pkg::rsp_payload_type rsp_payload
);

   logic [1:0] sub_ff, sub_in;
   logic       valid_ff, valid_in;
   logic       load;
   logic       final_byte;
   pdec_pkg::rsp_payload_type data_ff, data_in;

   assign load       = !valid_ff || !rsp_stall;
   assign final_byte = (sub_ff == head_cmd.count - 2'd1);
   assign pop        = load && head_valid && final_byte;

   always_comb begin
      sub_in   = sub_ff;
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = head_valid;
         if (head_valid) begin
            data_in.out_byte = head_cmd.data[sub_ff];
            data_in.out_last = head_cmd.last && final_byte;
            sub_in = final_byte ? 2'd0 : sub_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         sub_ff   <= sub_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = data_ff;

endmodule

### src/percent_decoder.sv
// ----------------------------------------------------------------------------
// percent_decoder
// Streaming form-style URL percent decoder.
// ----------------------------------------------------------------------------
// One encoded byte is taken per cycle while req_stall is low, and one decoded
// byte leaves per cycle while rsp_stall is low. A byte that decodes to a single
// character passes as one command; a broken escape or a flush on the final byte
// yields up to three characters, and the output register then emits them one by
// one from that command. The four-entry command queue between the classifier
// and the output stage absorbs these bursts, and req_stall rises only while
// that queue is full.
module percent_decoder (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  pdec_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output pdec_pkg::rsp_payload_type rsp_payload
);

   pdec_pkg::cmd_type cmd, head_cmd;
   logic accept, push, pop, empty, full;

   assign req_stall = full;
   assign accept    = req_valid && !req_stall;

   pdec_front u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_payload),
      .cmd    (cmd),
      .push   (push)
   );

   pdec_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .empty    (empty),
      .full     (full)
   );

   pdec_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_cmd    (head_cmd),
      .head_valid  (!empty),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   a_last_pushes: assert property (@(posedge clock) disable iff (reset)
      accept && req_payload.in_last |-> push)
      else $error("final byte produced no output command");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("command queue written while full");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("command queue read while empty");

endmodule
